// ===== design/assert_macros.svh =====
// Assertion macros for the design files; only step_delta_reporter.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SDR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SDR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/sdr_pkg.sv =====
// Types, codes and the pending-delta update shared by the step delta reporter.
package sdr_pkg;

    localparam logic [31:0] DEADLINE_GAP = 32'd60;
    localparam logic signed [31:0] INT32_MIN_C = 32'sh8000_0000;
    localparam logic signed [31:0] INT32_MAX_C = 32'sh7FFF_FFFF;
    localparam logic [31:0] UINT32_MAX_C = 32'hFFFF_FFFF;
    localparam logic signed [31:0] FIXED_UNAVAIL = INT32_MIN_C;

    typedef enum logic [1:0] {
        OP_CTX    = 2'd0,
        OP_READ   = 2'd1,
        OP_PREP   = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        AV_UNKNOWN     = 2'd0,
        AV_AVAILABLE   = 2'd1,
        AV_UNAVAILABLE = 2'd2
    } avail_t;

    typedef struct packed {
        op_t                op;
        logic               step_src_on;
        logic               proj_ok;
        logic               rec_live;
        logic               snap_new;
        logic [31:0]        recording_low;
        logic [31:0]        recording_high;
        logic               may_deliver;
        logic               accessible;
        logic signed [63:0] total_steps;
        logic [31:0]        now_time;
    } item_t;

    typedef struct packed {
        logic               render;
        logic               sample_req;
        logic               prep_dropped;
        logic               packet_valid;
        logic [31:0]        packet_rec_low;
        logic [31:0]        packet_rec_high;
        logic [31:0]        packet_sequence;
        logic signed [31:0] packet_delta;
        logic               deadline_valid;
        logic [31:0]        next_deadline;
        logic               is_available;
        logic               has_outbound;
    } result_t;

    typedef struct packed {
        logic               flag;
        logic [63:0]        rec;
        logic signed [31:0] sum;
    } pend_t;

    typedef struct packed {
        logic [3:0]         ctx;
        logic [63:0]        cur_rec;
        avail_t             avail;
        pend_t              pend;
        logic               bl_valid;
        logic [30:0]        bl_count;
        logic               dl_set;
        logic [31:0]        dl_time;
        logic               prep_flag;
        logic [63:0]        prep_rec;
        logic [31:0]        prep_seq;
        logic signed [31:0] prep_delta;
        logic [31:0]        next_seq;
        logic               seq_exh;
    } state_t;

    // Folds one delta into the pending packet of the current recording.
    function automatic pend_t add_delta(input pend_t p, input logic [63:0] cur_rec,
                                        input logic signed [31:0] delta,
                                        input logic signed [31:0] code);
        pend_t r;
        logic signed [32:0] s;
        r = p;
        s = {p.sum[31], p.sum} + {delta[31], delta};
        if (cur_rec != 64'd0) begin
            if (!r.flag || r.rec != cur_rec) begin
                r.flag = 1'b0;
                r.sum = '0;
            end
            if (delta == code) begin
                r.sum = code;
            end else if (!r.flag || r.sum == code) begin
                r.sum = delta;
            end else if (s[32] != s[31]) begin
                r.sum = s[32] ? INT32_MIN_C : INT32_MAX_C;
            end else begin
                r.sum = s[31:0];
            end
            r.rec = cur_rec;
            r.flag = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== design/step_delta_reporter.sv =====
// Top level of the step delta reporter: stream ports, register port and item pipeline.
//
//   Port group   Direction  Carries
//   s_*          in         one item per transfer, op in s_tuser
//   m_*          out        one result per transfer
//   APB          in/out     unavailable_code register at any address with paddr[2] low
//
// Each item passes from input transfer to result through an input register,
// then one pass of next-state logic into the result register.
// One item is accepted per cycle; the result register holds a valid result while m_tready is low,
// and the input register keeps taking an item as long as the result can move on.
// Reset is synchronous on aresetn low and clears the valid flags and the state register; unavailable_code
// returns to the most negative 32-bit value.
module step_delta_reporter
    import sdr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] step_src_on, [1] proj_ok, [2] rec_live,
    // [3] snap_new, [35:4] recording_low, [67:36] recording_high,
    // [68] may_deliver, [69] accessible, [133:70] total_steps,
    // [165:134] now_time, [167:166] zero
    input  logic [167:0] s_tdata,
    // [1:0] op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] render, [1] sample_req, [2] prep_dropped, [3] packet_valid,
    // [35:4] packet_rec_low, [67:36] packet_rec_high, [99:68] packet_sequence,
    // [131:100] packet_delta, [132] deadline_valid, [164:133] next_deadline,
    // [165] is_available, [166] has_outbound, [167] zero
    output logic [167:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    `include "assert_macros.svh"

    logic               in_valid_reg;
    logic               in_valid_next;
    item_t              item_reg;
    item_t              item_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            res_reg;
    result_t            res_next;
    state_t             state_reg;
    state_t             state_next;
    logic signed [31:0] code_reg;
    logic               s_accept;
    logic               advance;
    logic               cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'b0) ? code_reg : 32'd0;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign item_next.op = op_t'(s_tuser);
    assign item_next.step_src_on = s_tdata[0];
    assign item_next.proj_ok = s_tdata[1];
    assign item_next.rec_live = s_tdata[2];
    assign item_next.snap_new = s_tdata[3];
    assign item_next.recording_low = s_tdata[35:4];
    assign item_next.recording_high = s_tdata[67:36];
    assign item_next.may_deliver = s_tdata[68];
    assign item_next.accessible = s_tdata[69];
    assign item_next.total_steps = s_tdata[133:70];
    assign item_next.now_time = s_tdata[165:134];

    sdr_step u_step (
        .cur_state    (state_reg),
        .item         (item_reg),
        .unavail_code (code_reg),
        .next_state   (state_next),
        .result       (res_next)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '0;
            code_reg <= INT32_MIN_C;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
            if (cfg_write && (paddr[2] == 1'b0)) begin
                code_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_next;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {1'b0, res_reg.has_outbound, res_reg.is_available,
                      res_reg.next_deadline, res_reg.deadline_valid,
                      res_reg.packet_delta, res_reg.packet_sequence,
                      res_reg.packet_rec_high, res_reg.packet_rec_low,
                      res_reg.packet_valid, res_reg.prep_dropped,
                      res_reg.sample_req, res_reg.render};

    `SDR_ASSERT_NOW(a_exh_seq_max, aclk, aresetn, state_reg.seq_exh,
                    state_reg.next_seq == UINT32_MAX_C)
    `SDR_ASSERT_NOW(a_pend_has_rec, aclk, aresetn, state_reg.pend.flag,
                    state_reg.pend.rec != 64'd0)
    `SDR_ASSERT_NOW(a_no_packet_zero, aclk, aresetn, m_tvalid && !res_reg.packet_valid,
                    res_reg.packet_sequence == 32'd0 && res_reg.packet_delta == 32'sd0)
    `SDR_ASSERT_NEXT(a_advance_shows, aclk, aresetn, advance, m_tvalid)

endmodule

// ===== design/sdr_step.sv =====
// Next-state and result logic for one item of the step delta reporter.
module sdr_step
    import sdr_pkg::*;
(
    input  state_t             cur_state,
    input  item_t              item,
    input  logic signed [31:0] unavail_code,
    output state_t             next_state,
    output result_t            result
);

    logic [63:0] rec;
    logic        act;
    logic        changed;
    logic        sampling_old;
    logic        sampling_new;
    logic        good;
    logic [30:0] steps;
    logic [30:0] diff;
    logic        dv;
    state_t      ns;
    result_t     res;

    always_comb begin
        ns = cur_state;
        res = '0;
        rec = {item.recording_high, item.recording_low};
        act = item.rec_live && (rec != 64'd0);
        changed = (cur_state.ctx[2] != act) || (act && (cur_state.cur_rec != rec));
        sampling_old = (cur_state.ctx == 4'hF) && (cur_state.cur_rec != 64'd0);
        good = item.accessible && (item.total_steps[63:31] == 33'd0);
        steps = item.total_steps[30:0];
        diff = (steps >= cur_state.bl_count) ? steps - cur_state.bl_count : steps;

        unique case (item.op)
            OP_CTX: begin
                if (changed) begin
                    ns.pend.flag = 1'b0;
                    if (cur_state.prep_flag && (cur_state.prep_rec != rec)
                        && !item.may_deliver) begin
                        ns.prep_flag = 1'b0;
                        res.prep_dropped = 1'b1;
                    end
                    ns.bl_valid = 1'b0;
                    ns.avail = AV_UNKNOWN;
                    ns.dl_set = 1'b0;
                end
                ns.ctx = {item.snap_new, act, item.proj_ok,
                          item.step_src_on};
                ns.cur_rec = act ? rec : 64'd0;
                if (!((ns.ctx == 4'hF) && (ns.cur_rec != 64'd0))) begin
                    ns.bl_valid = 1'b0;
                    ns.dl_set = 1'b0;
                    if (act && (ns.avail != AV_UNAVAILABLE)) begin
                        ns.avail = AV_UNAVAILABLE;
                        ns.pend = add_delta(ns.pend, ns.cur_rec, FIXED_UNAVAIL,
                                            FIXED_UNAVAIL);
                        res.render = 1'b1;
                    end
                end else if (!ns.dl_set) begin
                    res.sample_req = 1'b1;
                end
            end
            OP_READ: begin
                if (sampling_old) begin
                    ns.dl_set = 1'b1;
                    ns.dl_time = item.now_time + DEADLINE_GAP;
                    if (!good) begin
                        ns.bl_valid = 1'b0;
                        if (cur_state.avail != AV_UNAVAILABLE) begin
                            ns.avail = AV_UNAVAILABLE;
                            ns.pend = add_delta(ns.pend, cur_state.cur_rec, unavail_code,
                                                unavail_code);
                            res.render = 1'b1;
                        end
                    end else begin
                        ns.bl_count = steps;
                        ns.bl_valid = 1'b1;
                        if (cur_state.avail != AV_AVAILABLE) begin
                            ns.avail = AV_AVAILABLE;
                            ns.pend = add_delta(ns.pend, cur_state.cur_rec, 32'sd0,
                                                unavail_code);
                            res.render = 1'b1;
                        end
                        if (cur_state.bl_valid && (diff != 31'd0)) begin
                            ns.pend = add_delta(ns.pend, cur_state.cur_rec, {1'b0, diff},
                                                unavail_code);
                        end
                    end
                end
            end
            OP_PREP: begin
                if (cur_state.prep_flag) begin
                    res.packet_valid = 1'b1;
                end else if (cur_state.pend.flag && !cur_state.seq_exh) begin
                    ns.prep_rec = cur_state.pend.rec;
                    ns.prep_seq = cur_state.next_seq;
                    ns.prep_delta = cur_state.pend.sum;
                    ns.pend.flag = 1'b0;
                    ns.prep_flag = 1'b1;
                    if (cur_state.next_seq == UINT32_MAX_C) begin
                        ns.seq_exh = 1'b1;
                    end else begin
                        ns.next_seq = cur_state.next_seq + 32'd1;
                    end
                    res.packet_valid = 1'b1;
                end
                if (res.packet_valid) begin
                    res.packet_rec_low = ns.prep_rec[31:0];
                    res.packet_rec_high = ns.prep_rec[63:32];
                    res.packet_sequence = ns.prep_seq;
                    res.packet_delta = ns.prep_delta;
                end
            end
            OP_FINISH: begin
                ns.prep_flag = 1'b0;
            end
            default: begin
                ns = cur_state;
            end
        endcase

        sampling_new = (ns.ctx == 4'hF) && (ns.cur_rec != 64'd0);
        dv = sampling_new && ns.dl_set;
        res.deadline_valid = dv;
        res.next_deadline = dv ? ns.dl_time : 32'd0;
        res.is_available = (ns.avail == AV_AVAILABLE);
        res.has_outbound = ns.pend.flag || ns.prep_flag;
    end

    assign next_state = ns;
    assign result = res;

endmodule

// ===== bench/step_delta_reporter_checker.sv =====
// Checker for the step delta reporter: predicts each result from the input transfers and compares.
`timescale 1ns / 1ps

module step_delta_reporter_checker
    import sdr_pkg::*;
#(
    parameter logic [2:0] CODE_ADDR = 3'd0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // [0] step_src_on, [1] proj_ok, [2] rec_live,
    // [3] snap_new, [35:4] recording_low, [67:36] recording_high,
    // [68] may_deliver, [69] accessible, [133:70] total_steps,
    // [165:134] now_time, [167:166] zero
    input  logic [167:0] s_tdata,
    // [1:0] op
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [0] render, [1] sample_req, [2] prep_dropped, [3] packet_valid,
    // [35:4] packet_rec_low, [67:36] packet_rec_high, [99:68] packet_sequence,
    // [131:100] packet_delta, [132] deadline_valid, [164:133] next_deadline,
    // [165] is_available, [166] has_outbound, [167] zero
    input  logic [167:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic [31:0]  prdata,
    input  logic         pready,
    output int unsigned  fail_count,
    output int unsigned  outstanding
);

    logic signed [31:0] unavail_code;
    logic [3:0]         ctx_bits;
    logic [63:0]        live_rec;
    avail_t             avail;
    logic               pend_valid;
    logic [63:0]        pend_rec;
    logic signed [31:0] pend_sum;
    logic               base_valid;
    logic signed [31:0] base_count;
    logic               dl_armed;
    logic [31:0]        dl_time;
    logic               prep_valid;
    logic [63:0]        prep_rec;
    logic [31:0]        prep_seq;
    logic signed [31:0] prep_delta;
    logic [31:0]        seq_next;
    logic               seq_done;

    result_t            expected_results[$];
    int unsigned        result_no;

    task automatic note_mismatch(input string what);
        $display("check: %s", what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("result %0d: %s is %h, expected %h",
                                    result_no, name, got, want));
        end
    endtask

    function automatic logic sampling_live();
        return ctx_bits == 4'hF && live_rec != 64'd0;
    endfunction

    function automatic void fold_delta(input logic signed [31:0] delta,
                                       input logic signed [31:0] code);
        longint total;
        total = longint'(pend_sum) + longint'(delta);
        if (live_rec == 64'd0) begin
            return;
        end
        if (!pend_valid || pend_rec != live_rec) begin
            pend_valid = 1'b0;
            pend_sum = '0;
            total = longint'(delta);
        end
        if (delta == code) begin
            pend_sum = code;
        end else if (!pend_valid || pend_sum == code) begin
            pend_sum = delta;
        end else if (total > longint'(INT32_MAX_C)) begin
            pend_sum = INT32_MAX_C;
        end else if (total < longint'(INT32_MIN_C)) begin
            pend_sum = INT32_MIN_C;
        end else begin
            pend_sum = total[31:0];
        end
        pend_rec = live_rec;
        pend_valid = 1'b1;
    endfunction

    function automatic logic go_unavailable(input logic signed [31:0] code);
        if (!ctx_bits[2] || live_rec == 64'd0 || avail == AV_UNAVAILABLE) begin
            return 1'b0;
        end
        avail = AV_UNAVAILABLE;
        fold_delta(code, code);
        return 1'b1;
    endfunction

    function automatic logic go_available(input logic signed [31:0] code);
        if (avail == AV_AVAILABLE) begin
            return 1'b0;
        end
        avail = AV_AVAILABLE;
        fold_delta(32'sd0, code);
        return 1'b1;
    endfunction

    function automatic result_t apply_item(input item_t it);
        result_t            r;
        logic [63:0]        rec;
        logic               act;
        logic               changed;
        logic signed [31:0] cur;
        logic signed [31:0] d;
        r = '0;
        case (it.op)
            OP_CTX: begin
                rec = {it.recording_high, it.recording_low};
                act = it.rec_live && rec != 64'd0;
                changed = (ctx_bits[2] != act) || (act && live_rec != rec);
                if (changed) begin
                    pend_valid = 1'b0;
                    if (prep_valid && prep_rec != rec && !it.may_deliver) begin
                        prep_valid = 1'b0;
                        r.prep_dropped = 1'b1;
                    end
                    base_valid = 1'b0;
                    avail = AV_UNKNOWN;
                    dl_armed = 1'b0;
                end
                ctx_bits = {it.snap_new, act, it.proj_ok, it.step_src_on};
                live_rec = act ? rec : 64'd0;
                if (!sampling_live()) begin
                    base_valid = 1'b0;
                    dl_armed = 1'b0;
                    r.render = go_unavailable(FIXED_UNAVAIL);
                end else if (!dl_armed) begin
                    r.sample_req = 1'b1;
                end
            end
            OP_READ: begin
                if (sampling_live()) begin
                    dl_armed = 1'b1;
                    dl_time = it.now_time + DEADLINE_GAP;
                    if (!it.accessible || it.total_steps < 0
                        || it.total_steps > 64'sh7FFF_FFFF) begin
                        base_valid = 1'b0;
                        r.render = go_unavailable(unavail_code);
                    end else begin
                        cur = it.total_steps[31:0];
                        if (!base_valid) begin
                            base_count = cur;
                            base_valid = 1'b1;
                            r.render = go_available(unavail_code);
                        end else begin
                            d = (cur >= base_count) ? cur - base_count : cur;
                            base_count = cur;
                            r.render = go_available(unavail_code);
                            if (d > 0) begin
                                fold_delta(d, unavail_code);
                            end
                        end
                    end
                end
            end
            OP_PREP: begin
                if (!prep_valid && pend_valid && !seq_done) begin
                    prep_rec = pend_rec;
                    prep_seq = seq_next;
                    prep_delta = pend_sum;
                    pend_valid = 1'b0;
                    prep_valid = 1'b1;
                    if (seq_next == UINT32_MAX_C) begin
                        seq_done = 1'b1;
                    end else begin
                        seq_next++;
                    end
                end
                if (prep_valid) begin
                    r.packet_valid = 1'b1;
                    r.packet_rec_low = prep_rec[31:0];
                    r.packet_rec_high = prep_rec[63:32];
                    r.packet_sequence = prep_seq;
                    r.packet_delta = prep_delta;
                end
            end
            OP_FINISH: begin
                prep_valid = 1'b0;
            end
        endcase
        r.deadline_valid = sampling_live() && dl_armed;
        r.next_deadline = r.deadline_valid ? dl_time : 32'd0;
        r.is_available = avail == AV_AVAILABLE;
        r.has_outbound = pend_valid || prep_valid;
        return r;
    endfunction

    always @(posedge aclk) begin
        item_t   seen;
        result_t want;
        if (!aresetn) begin
            unavail_code = INT32_MIN_C;
            ctx_bits = '0;
            live_rec = '0;
            avail = AV_UNKNOWN;
            pend_valid = 1'b0;
            pend_rec = '0;
            pend_sum = '0;
            base_valid = 1'b0;
            base_count = '0;
            dl_armed = 1'b0;
            dl_time = '0;
            prep_valid = 1'b0;
            prep_rec = '0;
            prep_seq = '0;
            prep_delta = '0;
            seq_next = '0;
            seq_done = 1'b0;
            expected_results.delete();
            fail_count = 0;
            result_no = 0;
        end else begin
            if (psel && penable && pready && paddr == CODE_ADDR) begin
                if (pwrite) begin
                    unavail_code = pwdata;
                end else if (prdata !== unavail_code) begin
                    note_mismatch($sformatf("register read %h, expected %h",
                                            prdata, unavail_code));
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with none expected",
                                            result_no));
                end else begin
                    want = expected_results.pop_front();
                    check_field("render", 32'(m_tdata[0]), 32'(want.render));
                    check_field("sample_req", 32'(m_tdata[1]), 32'(want.sample_req));
                    check_field("prep_dropped", 32'(m_tdata[2]), 32'(want.prep_dropped));
                    check_field("packet_valid", 32'(m_tdata[3]), 32'(want.packet_valid));
                    check_field("packet_rec_low", m_tdata[35:4], want.packet_rec_low);
                    check_field("packet_rec_high", m_tdata[67:36], want.packet_rec_high);
                    check_field("packet_sequence", m_tdata[99:68], want.packet_sequence);
                    check_field("packet_delta", m_tdata[131:100], want.packet_delta);
                    check_field("deadline_valid", 32'(m_tdata[132]),
                                32'(want.deadline_valid));
                    check_field("next_deadline", m_tdata[164:133], want.next_deadline);
                    check_field("is_available", 32'(m_tdata[165]), 32'(want.is_available));
                    check_field("has_outbound", 32'(m_tdata[166]), 32'(want.has_outbound));
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                seen.op = op_t'(s_tuser);
                seen.step_src_on = s_tdata[0];
                seen.proj_ok = s_tdata[1];
                seen.rec_live = s_tdata[2];
                seen.snap_new = s_tdata[3];
                seen.recording_low = s_tdata[35:4];
                seen.recording_high = s_tdata[67:36];
                seen.may_deliver = s_tdata[68];
                seen.accessible = s_tdata[69];
                seen.total_steps = s_tdata[133:70];
                seen.now_time = s_tdata[165:134];
                expected_results.push_back(apply_item(seen));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== bench/step_delta_reporter_tb.sv =====
// Testbench top for the step delta reporter: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps

module step_delta_reporter_tb;
    import sdr_pkg::*;

    localparam logic [2:0]  CODE_ADDR     = 3'd0;
    localparam int          IDLE_LIMIT    = 2000;
    localparam int          RX_HOLD       = 300;
    localparam int          PHASE_ITEMS   = 112;
    localparam logic [63:0] REC_A         = 64'h0000_0000_0000_0001;
    localparam logic [63:0] REC_B         = 64'h0000_0001_0000_0000;
    localparam logic [63:0] REC_C         = 64'h0000_0002_8000_0001;
    localparam logic [63:0] REC_TOP       = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int unsigned  fail_count;
    int unsigned  outstanding;
    int unsigned  stall_cycles = 0;

    logic         tx_steady = 1'b0;
    logic         rx_steady = 1'b0;
    int           rx_hold_reqs = 0;
    int           rx_hold_seen = 0;
    int           rx_wait = 0;
    longint       steps_now = 0;
    logic [63:0]  live_pick = REC_A;

    always #2 aclk = ~aclk;

    step_delta_reporter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    step_delta_reporter_checker #(
        .CODE_ADDR (CODE_ADDR)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // The receiver stalls at random, holds off for a long stretch on request,
    // or stays ready throughout a steady phase.
    always @(negedge aclk) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (rx_hold_seen != rx_hold_reqs) begin
            m_tready <= 1'b0;
            rx_hold_seen = rx_hold_reqs;
            rx_wait = RX_HOLD - 1;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else if (rx_steady || pick < 65) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            rx_wait = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic item_t noise_item();
        item_t it;
        it.op = op_t'($urandom_range(0, 3));
        {it.step_src_on, it.proj_ok,
         it.rec_live, it.snap_new} = 4'($urandom_range(0, 15));
        it.recording_low = $urandom;
        it.recording_high = $urandom;
        it.may_deliver = 1'($urandom_range(0, 1));
        it.accessible = 1'($urandom_range(0, 1));
        it.total_steps = {$urandom, $urandom};
        it.now_time = $urandom;
        return it;
    endfunction

    function automatic item_t ctx_item(input logic [3:0] flags, input logic [63:0] rec,
                                       input logic may);
        item_t it;
        it = noise_item();
        it.op = OP_CTX;
        {it.snap_new, it.rec_live,
         it.proj_ok, it.step_src_on} = flags;
        {it.recording_high, it.recording_low} = rec;
        it.may_deliver = may;
        return it;
    endfunction

    function automatic item_t read_item(input logic acc, input logic signed [63:0] total,
                                        input logic [31:0] now);
        item_t it;
        it = noise_item();
        it.op = OP_READ;
        it.accessible = acc;
        it.total_steps = total;
        it.now_time = now;
        return it;
    endfunction

    function automatic item_t op_item(input op_t op);
        item_t it;
        it = noise_item();
        it.op = op;
        return it;
    endfunction

    // Mostly a live recording with a counter that climbs, now and then resets or
    // jumps, with bad readings, identity changes and packet traffic mixed in.
    function automatic item_t shaped_item();
        item_t it;
        int    pick;
        it = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.op = OP_CTX;
            if ($urandom_range(0, 9) < 7) begin
                {it.step_src_on, it.proj_ok,
                 it.rec_live, it.snap_new} = 4'hF;
            end
            case ($urandom_range(0, 9))
                7, 8: begin
                    case ($urandom_range(0, 3))
                        0: live_pick = REC_A;
                        1: live_pick = REC_B;
                        2: live_pick = REC_C;
                        default: live_pick = REC_TOP;
                    endcase
                    {it.recording_high, it.recording_low} = live_pick;
                end
                9: begin
                    if ($urandom_range(0, 1) == 0) begin
                        {it.recording_high, it.recording_low} = 64'd0;
                    end
                end
                default: {it.recording_high, it.recording_low} = live_pick;
            endcase
        end else if (pick < 70) begin
            it.op = OP_READ;
            it.accessible = $urandom_range(0, 19) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                steps_now = steps_now + $urandom_range(0, 40);
                it.total_steps = steps_now;
            end else if (pick < 83) begin
                steps_now = $urandom_range(0, 20);
                it.total_steps = steps_now;
            end else if (pick < 90) begin
                steps_now = steps_now + $urandom_range(0, 32'h7FFF_FFFF);
                it.total_steps = steps_now;
            end else if (pick < 94) begin
                it.total_steps[63] = 1'b1;
            end else if (pick < 97) begin
                it.total_steps = {1'b0, it.total_steps[62:0]};
            end else begin
                it.total_steps = 64'sh7FFF_FFFF;
            end
            if (steps_now > 64'sh7FFF_FFFF) begin
                steps_now = $urandom_range(0, 100);
            end
        end else if (pick < 85) begin
            it.op = OP_PREP;
        end else begin
            it.op = OP_FINISH;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        int pick;
        gap = 0;
        pick = $urandom_range(0, 99);
        if (!tx_steady && pick >= 60) begin
            gap = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {2'b00, it.now_time, it.total_steps, it.accessible, it.may_deliver,
                    it.recording_high, it.recording_low, it.snap_new,
                    it.rec_live, it.proj_ok, it.step_src_on};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= CODE_ADDR;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [31:0] code;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        apb_access(1'b0, 32'd0);

        send_item(op_item(OP_PREP));
        send_item(op_item(OP_FINISH));
        send_item(read_item(1'b1, 64'sd100, 32'd0));
        send_item(ctx_item(4'hF, REC_A, 1'b0));
        send_item(read_item(1'b1, 64'sd100, 32'hFFFF_FFF0));
        send_item(read_item(1'b1, 64'sd150, 32'd10));
        send_item(read_item(1'b1, 64'sd20, 32'd20));
        send_item(read_item(1'b1, 64'sh7FFF_FFFF, 32'd30));
        send_item(read_item(1'b1, 64'sd5, 32'd40));
        send_item(read_item(1'b1, 64'sh7FFF_FFFF, 32'd50));
        send_item(read_item(1'b1, -64'sd1, 32'd60));
        send_item(read_item(1'b1, 64'sh8000_0000, 32'd70));
        send_item(read_item(1'b0, 64'sd10, 32'd80));
        send_item(read_item(1'b1, 64'sd10, 32'd90));
        send_item(op_item(OP_PREP));
        send_item(op_item(OP_PREP));
        send_item(ctx_item(4'hF, REC_B, 1'b0));
        send_item(read_item(1'b1, 64'sd1000, 32'd100));
        send_item(read_item(1'b1, 64'sd1010, 32'd110));
        send_item(op_item(OP_PREP));
        send_item(ctx_item(4'hF, REC_C, 1'b1));
        send_item(op_item(OP_FINISH));
        send_item(ctx_item(4'h7, REC_C, 1'b0));
        send_item(ctx_item(4'hB, REC_C, 1'b0));
        send_item(ctx_item(4'hF, REC_TOP, 1'b0));
        send_item(read_item(1'b1, 64'sh7FFF_FFFF_FFFF_FFFF, 32'd0));
        send_item(read_item(1'b1, 64'sh8000_0000_0000_0000, 32'hFFFF_FFFF));

        for (int p = 0; p < 10; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1: code = 32'd0;
                    2: code = 32'd7;
                    3: code = 32'h7FFF_FFFF;
                    4: code = 32'hFFFF_FFFF;
                    6: code = 32'd3;
                    7: code = 32'h8000_0000;
                    9: code = 32'd1;
                    default: code = $urandom;
                endcase
                apb_access(1'b1, code);
                apb_access(1'b0, 32'd0);
            end
            tx_steady = (p == 2 || p == 4);
            rx_steady <= (p == 4);
            if (p == 2) begin
                rx_hold_reqs <= rx_hold_reqs + 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(shaped_item());
            end
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
